FILE: hw/rtl/trle_pkg.sv
// Shared types and constants for the transparent run-length encoder.
// No dependencies; imported by trle_step, trle_outq and the top level.
`default_nettype none

package trle_pkg;

  localparam int DefMaxRun     = 127;
  localparam int DefOffsetW    = 28;
  localparam int OutOffsetW    = 28;
  localparam int RunW          = 7;
  localparam int PixelW        = 8;
  localparam int MaxResults    = 4;
  localparam int NumW          = $clog2(MaxResults + 1);
  localparam int QueueDepth    = 8;
  localparam int QueueCntW     = $clog2(QueueDepth + 1);
  localparam int QueueIdxW     = $clog2(QueueDepth);
  localparam int InDataW       = 8;
  localparam int OutDataW      = 40;

  localparam logic [PixelW-1:0] TransFlag = 8'h80;
  localparam logic [PixelW-1:0] RowTerm   = 8'h80;

  typedef struct packed {
    logic                  last;
    logic [OutOffsetW-1:0] offset;
    logic [PixelW-1:0]     data;
  } result_t;

  typedef struct packed {
    logic [NumW-1:0]                 num;
    result_t [MaxResults-1:0]        res;
  } push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/trle_step.sv
// Encoder state and per-pixel step logic: run tracking, offsets, result set.
// Depends on trle_pkg.
`default_nettype none

module trle_step #(
  parameter int MAX_RUN      = trle_pkg::DefMaxRun,
  parameter int OFFSET_WIDTH = trle_pkg::DefOffsetW
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [trle_pkg::PixelW-1:0] pixel_i,
  input  wire logic                        row_end_i,
  input  wire logic                        image_start_i,
  output trle_pkg::push_t                  push_o
);
  import trle_pkg::*;

  logic [OFFSET_WIDTH-1:0] wo_q, wo_d, co_q, co_d;
  logic [RunW-1:0]         len_q, len_d;
  logic                    rt_q, rt_d, open_q, open_d;
  logic                    trans;
  push_t                   push;

  function automatic result_t mk_res(logic [PixelW-1:0] b, logic [OFFSET_WIDTH-1:0] off);
    logic [OFFSET_WIDTH+OutOffsetW-1:0] ext;
    result_t r;
    ext      = {{OutOffsetW{1'b0}}, off};
    r.last   = 1'b0;
    r.offset = ext[OutOffsetW-1:0];
    r.data   = b;
    return r;
  endfunction

  always_comb begin
    trans  = (pixel_i == '0);
    push   = '0;
    wo_d   = wo_q;
    co_d   = co_q;
    len_d  = len_q;
    rt_d   = rt_q;
    open_d = open_q;

    if (image_start_i) begin
      open_d = 1'b0;
      len_d  = '0;
      wo_d   = '0;
      co_d   = '0;
    end

    // pixel of the other kind closes the open run
    if (open_d && (rt_d != trans)) begin
      if (!rt_d) begin
        push.res[push.num[1:0]] = mk_res({1'b0, len_d}, co_d);
        push.num = push.num + NumW'(1);
      end else begin
        push.res[push.num[1:0]] = mk_res(TransFlag | {1'b0, len_d}, wo_d);
        push.num = push.num + NumW'(1);
        wo_d = wo_d + OFFSET_WIDTH'(1);
      end
      open_d = 1'b0;
      len_d  = '0;
    end

    if (!open_d) begin
      open_d = 1'b1;
      rt_d   = trans;
      len_d  = '0;
      if (!trans) begin
        co_d = wo_d;
        wo_d = wo_d + OFFSET_WIDTH'(1);
      end
    end

    if (!trans) begin
      push.res[push.num[1:0]] = mk_res(pixel_i, wo_d);
      push.num = push.num + NumW'(1);
      wo_d = wo_d + OFFSET_WIDTH'(1);
    end
    len_d = len_d + RunW'(1);

    if (row_end_i) begin
      // trailing transparent run is dropped
      if (!rt_d) begin
        push.res[push.num[1:0]] = mk_res({1'b0, len_d}, co_d);
        push.num = push.num + NumW'(1);
      end
      push.res[push.num[1:0]] = mk_res(RowTerm, wo_d);
      push.num = push.num + NumW'(1);
      wo_d   = wo_d + OFFSET_WIDTH'(1);
      open_d = 1'b0;
      len_d  = '0;
    end else if (len_d >= RunW'(MAX_RUN)) begin
      if (!rt_d) begin
        push.res[push.num[1:0]] = mk_res({1'b0, len_d}, co_d);
        push.num = push.num + NumW'(1);
      end else begin
        push.res[push.num[1:0]] = mk_res(TransFlag | {1'b0, len_d}, wo_d);
        push.num = push.num + NumW'(1);
        wo_d = wo_d + OFFSET_WIDTH'(1);
      end
      open_d = 1'b0;
      len_d  = '0;
    end

    for (int k = 0; k < MaxResults; k++) begin
      push.res[k].last = (NumW'(k + 1) == push.num);
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wo_q   <= '0;
      co_q   <= '0;
      len_q  <= '0;
      rt_q   <= 1'b0;
      open_q <= 1'b0;
    end else if (accept_i) begin
      wo_q   <= wo_d;
      co_q   <= co_d;
      len_q  <= len_d;
      rt_q   <= rt_d;
      open_q <= open_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/trle_outq.sv
// Result queue: takes up to four results per cycle, hands out one per cycle while ready_i is high.
// Head entry is the registered output. Depends on trle_pkg.
`default_nettype none

module trle_outq (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_en_i,
  input  wire trle_pkg::push_t push_i,
  output logic         space_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output trle_pkg::result_t head_o
);
  import trle_pkg::*;

  result_t               q_q [QueueDepth];
  result_t               q_d [QueueDepth];
  logic [QueueCntW-1:0]  cnt_q, cnt_d, cnt_after;
  logic [QueueIdxW-1:0]  idx;
  logic                  pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = q_q[0];
  assign space_o = (cnt_q <= QueueCntW'(QueueDepth - MaxResults));
  assign pop     = valid_o && ready_i;

  always_comb begin
    cnt_after = cnt_q - {{(QueueCntW-1){1'b0}}, pop};
    idx       = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (pop && (i < QueueDepth - 1)) begin
        q_d[i] = q_q[i+1];
      end else begin
        q_d[i] = q_q[i];
      end
    end
    cnt_d = cnt_after;
    if (push_en_i) begin
      for (int k = 0; k < MaxResults; k++) begin
        idx = cnt_after[QueueIdxW-1:0] + QueueIdxW'(k);
        if (NumW'(k) < push_i.num) begin
          q_d[idx] = push_i.res[k];
        end
      end
      cnt_d = cnt_after + QueueCntW'(push_i.num);
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/transparent_run_length_encoder.sv
// Transparent run-length encoder, top level.
// Depends on trle_pkg, trle_step, trle_outq.
//
// Usage: pixels enter on the s_axis channel, one 8-bit palette index per
// transaction, with tlast marking the last pixel of a row and tuser marking
// the first pixel of an image. Each pixel yields zero to four encoded bytes
// on the m_axis channel, each with its byte offset in the image's stream;
// m_axis_tlast marks the final byte caused by a pixel. Pixels that cause no
// byte (transparent, not ending a row or a run) produce no transaction.
// The bytes of a pixel reach m_axis from the registered head of the result
// queue, behind any bytes still queued. One pixel per cycle is taken as long as the
// eight-entry result queue holds at most four bytes; the output sends one
// byte per cycle while m_axis_tready is high.
// Reset clears the run state, the offset counter and the queue.
// When the receiver stalls, queued bytes hold and s_axis_tready drops once
// the queue could not take a pixel's worst-case four bytes.
`default_nettype none

module transparent_run_length_encoder #(
  parameter int MAX_RUN      = trle_pkg::DefMaxRun,
  parameter int OFFSET_WIDTH = trle_pkg::DefOffsetW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [trle_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] pixel
  input  wire logic                          s_axis_tlast,  // row_end
  input  wire logic                          s_axis_tuser,  // image_start
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [trle_pkg::OutDataW-1:0]      m_axis_tdata,  // [7:0] out_byte, [35:8] out_offset
  output logic                               m_axis_tlast   // last
);
  import trle_pkg::*;

  logic    accept;
  push_t   push;
  result_t head;

  assign accept = s_axis_tvalid && s_axis_tready;

  trle_step #(
    .MAX_RUN     (MAX_RUN),
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pixel_i      (s_axis_tdata[PixelW-1:0]),
    .row_end_i    (s_axis_tlast),
    .image_start_i(s_axis_tuser),
    .push_o       (push)
  );

  trle_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_en_i(accept),
    .push_i   (push),
    .space_o  (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .head_o   (head)
  );

  assign m_axis_tdata = {{(OutDataW-OutOffsetW-PixelW){1'b0}}, head.offset, head.data};
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

FILE: hw/rtl/trle_chk.sv
// Port-level checker for the transparent run-length encoder, bound to the top.
// Depends on transparent_run_length_encoder port names only.
`default_nettype none

module trle_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // opaque pixel or row end always yields output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tdata != 8'h00)
      |=> m_axis_tvalid)
    else $error("missing output for pixel");

  // opaque first pixel of an image lands at offset 1 behind its count slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tdata != 8'h00
      && !m_axis_tvalid
      |=> m_axis_tdata[7:0] == $past(s_axis_tdata) && m_axis_tdata[35:8] == 28'd1)
    else $error("bad first pixel byte");

  // one-pixel transparent row at image start: only the terminator at offset 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast
      && s_axis_tdata == 8'h00 && !m_axis_tvalid
      |=> m_axis_tdata[7:0] == 8'h80 && m_axis_tdata[35:8] == 28'd0 && m_axis_tlast)
    else $error("bad row terminator");

endmodule

bind transparent_run_length_encoder trle_chk u_trle_chk (.*);

`default_nettype wire
